[rtl/rpv_pkg.sv]
// Shared types, constants and check functions for the relative path validator.
// Used by rpv_core, relative_path_validator, rpv_result_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rpv_pkg;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_EMPTY      = 4'd1,
    ERR_TOO_LONG   = 4'd2,
    ERR_ROOTED     = 4'd3,
    ERR_TOO_DEEP   = 4'd4,
    ERR_EMPTY_COMP = 4'd5,
    ERR_TRAVERSAL  = 4'd6,
    ERR_COMP_LONG  = 4'd7,
    ERR_BAD_CHAR   = 4'd8,
    ERR_RESERVED   = 4'd9
  } err_e;

  typedef enum logic [1:0] {
    REG_MAX_PATH_BYTES = 2'd0,
    REG_MAX_COMP_BYTES = 2'd1,
    REG_MAX_COMPONENTS = 2'd2
  } cfg_idx_e;

  localparam int unsigned PathLenW  = 16;
  localparam int unsigned CompLenW  = 10;
  localparam int unsigned CompNumW  = 8;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [PathLenW-1:0] MaxPathReset  = 16'd4096;
  localparam logic [CompLenW-1:0] MaxCompReset  = 10'd255;
  localparam logic [CompNumW-1:0] MaxCountReset = 8'd32;

  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChBSlash = 8'h5c;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChColon  = 8'h3a;

  // Reserved base names, first character in the lowest byte, zero padded.
  localparam logic [55:0] NameCon    = 56'h4E4F43;
  localparam logic [55:0] NamePrn    = 56'h4E5250;
  localparam logic [55:0] NameAux    = 56'h585541;
  localparam logic [55:0] NameNul    = 56'h4C554E;
  localparam logic [55:0] NameClock  = 56'h244B434F4C43;
  localparam logic [55:0] NameConin  = 56'h244E494E4F43;
  localparam logic [55:0] NameConout = 56'h2454554F4E4F43;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_path;
  } item_t;

  typedef struct packed {
    logic [7:0] path_byte;
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       final_item;
    err_e       error_code;
  } result_t;

  typedef struct packed {
    logic [PathLenW-1:0] max_path_bytes;
    logic [CompLenW-1:0] max_component_bytes;
    logic [CompNumW-1:0] max_components;
  } limits_t;

  typedef struct packed {
    logic [CompLenW-1:0] len;
    logic [6:0][7:0]     chars;
    logic [3:0]          base_len;
    logic                base_closed;
    logic [7:0]          prev;
    logic                bad_char;
    logic                len_over;
  } comp_t;

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_bad(input logic [7:0] b);
    return b < 8'h20 || b > 8'h7e || b == 8'h3c || b == 8'h3e || b == ChColon ||
           b == 8'h22 || b == 8'h7c || b == 8'h3f || b == 8'h2a;
  endfunction

  function automatic logic base_reserved(input comp_t c);
    logic [7:0] d;
    logic       named;
    logic       numbered;
    d = c.chars[3];
    named = (c.base_len == 4'd3 && (c.chars == NameCon || c.chars == NamePrn ||
                                    c.chars == NameAux || c.chars == NameNul)) ||
            (c.base_len == 4'd6 && (c.chars == NameClock || c.chars == NameConin)) ||
            (c.base_len == 4'd7 && c.chars == NameConout);
    numbered = c.base_len == 4'd4 && d >= 8'h30 && d <= 8'h39 &&
               ((c.chars[0] == 8'h43 && c.chars[1] == 8'h4F && c.chars[2] == 8'h4D) ||
                (c.chars[0] == 8'h4C && c.chars[1] == 8'h50 && c.chars[2] == 8'h54));
    return named || numbered;
  endfunction

  // Verdict on a component as it closes, depth first.
  function automatic err_e comp_error(input comp_t c, input logic [CompNumW-1:0] num,
                                      input logic [CompNumW-1:0] max_num);
    err_e e;
    if (num >= max_num) begin
      e = ERR_TOO_DEEP;
    end else if (c.len == '0) begin
      e = ERR_EMPTY_COMP;
    end else if (c.base_closed && c.base_len == 4'd0 &&
                 (c.len == CompLenW'(1) || (c.len == CompLenW'(2) && c.prev == ChDot))) begin
      e = ERR_TRAVERSAL;
    end else if (c.len_over) begin
      e = ERR_COMP_LONG;
    end else if (c.prev == ChDot || c.prev == ChSpace || c.bad_char) begin
      e = ERR_BAD_CHAR;
    end else if (base_reserved(c)) begin
      e = ERR_RESERVED;
    end else begin
      e = ERR_NONE;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

[rtl/rpv_core.sv]
// Path state and per-byte checks of the relative path validator.
// Holds the counters and component record; depends on rpv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpv_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire rpv_pkg::item_t   item_i,
  input  wire rpv_pkg::limits_t lim_i,
  output rpv_pkg::result_t      res_o
);
  import rpv_pkg::*;

  logic [PathLenW-1:0] path_len_q, path_len_d;
  logic                path_long_q, path_long_d;
  logic                rooted_q, rooted_d;
  logic [CompNumW-1:0] comp_num_q, comp_num_d;
  err_e                first_err_q, first_err_d;
  comp_t               comp_q, comp_d;

  logic [7:0]          b;
  logic                has;
  logic                sep;
  comp_t               comp1;
  comp_t               comp_clear;
  logic [PathLenW-1:0] path_len1;
  logic                path_long1;
  logic                rooted1;
  logic [CompNumW-1:0] comp_num1;
  err_e                err1;
  err_e                err2;
  err_e                final_err;

  always_comb begin
    b          = item_i.in_byte;
    has        = item_i.has_byte;
    sep        = has && (b == ChSlash || b == ChBSlash);
    comp_clear = '0;

    path_len1  = path_len_q;
    path_long1 = path_long_q;
    rooted1    = rooted_q;
    comp_num1  = comp_num_q;
    err1       = first_err_q;
    comp1      = comp_q;

    if (has) begin
      if ((path_len_q == '0 && sep) || (path_len_q == PathLenW'(1) && b == ChColon)) begin
        rooted1 = 1'b1;
      end
      if (path_len_q >= lim_i.max_path_bytes) begin
        path_long1 = 1'b1;
      end
      if (path_len_q != '1) begin
        path_len1 = path_len_q + PathLenW'(1);
      end
    end

    if (sep) begin
      if (first_err_q == ERR_NONE) begin
        err1 = comp_error(comp_q, comp_num_q, lim_i.max_components);
      end
      if (comp_num_q != '1) begin
        comp_num1 = comp_num_q + CompNumW'(1);
      end
      comp1 = comp_clear;
    end else if (has) begin
      if (comp_q.len >= lim_i.max_component_bytes) begin
        comp1.len_over = 1'b1;
      end
      if (comp_q.len != '1) begin
        comp1.len = comp_q.len + CompLenW'(1);
      end
      if (is_bad(b)) begin
        comp1.bad_char = 1'b1;
      end
      if (!comp_q.base_closed) begin
        if (b == ChDot) begin
          comp1.base_closed = 1'b1;
        end else if (comp_q.base_len < 4'd8) begin
          if (comp_q.base_len < 4'd7) begin
            comp1.chars[comp_q.base_len[2:0]] = to_upper(b);
          end
          comp1.base_len = comp_q.base_len + 4'd1;
        end
      end
      comp1.prev = b;
    end

    err2 = err1;
    if (err1 == ERR_NONE) begin
      err2 = comp_error(comp1, comp_num1, lim_i.max_components);
    end

    priority if (path_len1 == '0) begin
      final_err = ERR_EMPTY;
    end else if (path_long1) begin
      final_err = ERR_TOO_LONG;
    end else if (rooted1) begin
      final_err = ERR_ROOTED;
    end else begin
      final_err = err2;
    end
  end

  always_comb begin
    if (item_i.end_of_path) begin
      path_len_d  = '0;
      path_long_d = 1'b0;
      rooted_d    = 1'b0;
      comp_num_d  = '0;
      first_err_d = ERR_NONE;
      comp_d      = comp_clear;
    end else begin
      path_len_d  = path_len1;
      path_long_d = path_long1;
      rooted_d    = rooted1;
      comp_num_d  = comp_num1;
      first_err_d = err1;
      comp_d      = comp1;
    end
  end

  always_comb begin
    res_o            = '0;
    res_o.byte_valid = has;
    res_o.final_item = item_i.end_of_path;
    if (has) begin
      res_o.path_byte = sep ? ChSlash : b;
      res_o.key_byte  = sep ? ChSlash : to_lower(b);
    end
    res_o.error_code = item_i.end_of_path ? final_err : ERR_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_len_q  <= '0;
      path_long_q <= 1'b0;
      rooted_q    <= 1'b0;
      comp_num_q  <= '0;
      first_err_q <= ERR_NONE;
      comp_q      <= '0;
    end else if (step_i) begin
      path_len_q  <= path_len_d;
      path_long_q <= path_long_d;
      rooted_q    <= rooted_d;
      comp_num_q  <= comp_num_d;
      first_err_q <= first_err_d;
      comp_q      <= comp_d;
    end
  end

endmodule

`default_nettype wire

[rtl/relative_path_validator.sv]
// Top level of the relative path validator: handshakes, limit registers and
// the input and result registers around rpv_core; depends on rpv_pkg.
//
// A path enters as a stream of beats on the input channel, one byte per beat
// with has_byte set, and the beat with end_of_path set closes the path. Every
// accepted beat, idle beats included, yields exactly one result beat with the
// normalized byte, its lower-cased key byte, and on the final beat the error
// code of the whole path. A beat is taken at an edge where valid is high and
// stall is low, on both channels.
// A beat goes through the input register and then the result register to become
// its result beat; each register holds one beat, and one beat per cycle flows
// through as long as the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register fills; in_stall_o rises only when both are full.
// The three limit registers take a write on any cycle (cfg_ready_o is always
// high) and should be changed only between paths. Reset empties both
// registers, restores the default limits and clears the path state.
`timescale 1ns / 1ps
`default_nettype none

module relative_path_validator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [7:0]                     in_byte_i,
  input  wire logic                           has_byte_i,
  input  wire logic                           end_of_path_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [7:0]                     path_byte_o,
  output      logic [7:0]                     key_byte_o,
  output      logic                           byte_valid_o,
  output      logic                           final_item_o,
  output      logic [3:0]                     error_code_o,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [rpv_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [rpv_pkg::CfgDataW-1:0]   cfg_data_i
);
  import rpv_pkg::*;

  limits_t lim_q;
  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    out_free;
  logic    in_free;
  logic    step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_free    = !in_valid_q || out_free;
  assign in_stall_o = !in_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.max_path_bytes      <= MaxPathReset;
      lim_q.max_component_bytes <= MaxCompReset;
      lim_q.max_components      <= MaxCountReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_PATH_BYTES: lim_q.max_path_bytes      <= cfg_data_i;
        REG_MAX_COMP_BYTES: lim_q.max_component_bytes <= cfg_data_i[CompLenW-1:0];
        REG_MAX_COMPONENTS: lim_q.max_components      <= cfg_data_i[CompNumW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_q.in_byte     <= in_byte_i;
      in_q.has_byte    <= has_byte_i;
      in_q.end_of_path <= end_of_path_i;
    end
  end

  rpv_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .lim_i  (lim_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign path_byte_o  = out_q.path_byte;
  assign key_byte_o   = out_q.key_byte;
  assign byte_valid_o = out_q.byte_valid;
  assign final_item_o = out_q.final_item;
  assign error_code_o = out_q.error_code;

  a_err_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !final_item_o |-> error_code_o == ERR_NONE)
    else $error("error code on a result that does not end a path");

  a_empty_has_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> path_byte_o == 8'h00 && key_byte_o == 8'h00)
    else $error("byte data on a result without a byte");

  a_no_backslash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> path_byte_o != ChBSlash && key_byte_o != ChBSlash)
    else $error("separator not normalized");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input taken while both registers are full and held");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result lost or changed");

endmodule

`default_nettype wire

[dv/rpv_result_checker.sv]
// Result checker for the relative path validator: follows every input beat and
// limit write, predicts each result beat and compares it field by field.
// Depends on rpv_pkg for the error codes, register indexes and result type.
`timescale 1ns / 1ps

module rpv_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          has_byte_i,
  input  logic                          end_of_path_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [7:0]                    path_byte_i,
  input  logic [7:0]                    key_byte_i,
  input  logic                          byte_valid_i,
  input  logic                          final_item_i,
  input  logic [3:0]                    error_code_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rpv_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [rpv_pkg::CfgDataW-1:0]  cfg_data_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   results_owed_o
);
  import rpv_pkg::*;

  logic [15:0]     lim_path;
  logic [9:0]      lim_comp;
  logic [7:0]      lim_depth;

  logic [15:0]     path_len;
  logic [9:0]      comp_len;
  logic [7:0]      comp_cnt;
  err_e            first_err;
  logic [6:0][7:0] stem_chars;
  logic [3:0]      stem_len;
  logic            stem_done;
  logic [7:0]      last_char;
  logic            comp_bad;
  logic            rooted;
  logic            path_over;
  logic            comp_over;

  result_t         owed_q[$];
  result_t         want;
  int unsigned     mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic logic byte_forbidden(input logic [7:0] b);
    case (b)
      "<", ">", ":", "\"", "|", "?", "*": return 1'b1;
      default: return b < 8'h20 || b > 8'h7e;
    endcase
  endfunction

  function automatic logic stem_is(input string name);
    if (stem_len != name.len()) return 1'b0;
    for (int i = 0; i < name.len(); i++) begin
      if (stem_chars[i] != name[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic stem_is_device();
    logic [23:0] prefix;
    logic [7:0]  digit;
    prefix = {stem_chars[0], stem_chars[1], stem_chars[2]};
    digit  = stem_chars[3];
    if (stem_is("CON") || stem_is("PRN") || stem_is("AUX") || stem_is("NUL") ||
        stem_is("CLOCK$") || stem_is("CONIN$") || stem_is("CONOUT$")) begin
      return 1'b1;
    end
    return stem_len == 4'd4 && digit >= "0" && digit <= "9" &&
           (prefix == "COM" || prefix == "LPT");
  endfunction

  function automatic err_e component_verdict();
    if (comp_len == '0) return ERR_EMPTY_COMP;
    if (stem_done && stem_len == '0 &&
        (comp_len == 10'd1 || (comp_len == 10'd2 && last_char == ChDot))) begin
      return ERR_TRAVERSAL;
    end
    if (comp_over) return ERR_COMP_LONG;
    if (last_char == ChDot || last_char == ChSpace || comp_bad) return ERR_BAD_CHAR;
    if (stem_is_device()) return ERR_RESERVED;
    return ERR_NONE;
  endfunction

  task automatic clear_component();
    comp_len   = '0;
    stem_chars = '0;
    stem_len   = '0;
    stem_done  = 1'b0;
    last_char  = '0;
    comp_bad   = 1'b0;
    comp_over  = 1'b0;
  endtask

  task automatic clear_path();
    path_len  = '0;
    comp_cnt  = '0;
    first_err = ERR_NONE;
    rooted    = 1'b0;
    path_over = 1'b0;
    clear_component();
  endtask

  task automatic close_component();
    if (first_err == ERR_NONE) begin
      first_err = (comp_cnt >= lim_depth) ? ERR_TOO_DEEP : component_verdict();
    end
    if (comp_cnt != 8'hFF) comp_cnt++;
    clear_component();
  endtask

  task automatic take_path_beat(input logic [7:0] b, input logic has, input logic eop,
                                output result_t r);
    logic sep;
    r = '0;
    sep = b == ChSlash || b == ChBSlash;
    if (has) begin
      if ((path_len == '0 && sep) || (path_len == 16'd1 && b == ChColon)) rooted = 1'b1;
      if (path_len >= lim_path) path_over = 1'b1;
      if (path_len != 16'hFFFF) path_len++;
      if (sep) begin
        close_component();
        r.path_byte = ChSlash;
        r.key_byte  = ChSlash;
      end else begin
        if (comp_len >= lim_comp) comp_over = 1'b1;
        if (comp_len != 10'h3FF) comp_len++;
        if (byte_forbidden(b)) comp_bad = 1'b1;
        if (!stem_done) begin
          if (b == ChDot) begin
            stem_done = 1'b1;
          end else if (stem_len < 4'd8) begin
            if (stem_len < 4'd7) begin
              stem_chars[stem_len[2:0]] = (b >= "a" && b <= "z") ? {b[7:6], 1'b0, b[4:0]} : b;
            end
            stem_len++;
          end
        end
        last_char   = b;
        r.path_byte = b;
        r.key_byte  = (b >= "A" && b <= "Z") ? {b[7:6], 1'b1, b[4:0]} : b;
      end
    end
    if (eop) begin
      if (path_len == '0) begin
        r.error_code = ERR_EMPTY;
      end else begin
        close_component();
        r.error_code = path_over ? ERR_TOO_LONG : rooted ? ERR_ROOTED : first_err;
      end
      clear_path();
    end
    r.byte_valid = has;
    r.final_item = eop;
  endtask

  task automatic compare_field(input string field, input logic [7:0] expected,
                               input logic [7:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_path  = MaxPathReset;
      lim_comp  = MaxCompReset;
      lim_depth = MaxCountReset;
      clear_path();
      owed_q.delete();
      results_owed_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_PATH_BYTES: lim_path  = cfg_data_i;
          REG_MAX_COMP_BYTES: lim_comp  = cfg_data_i[9:0];
          REG_MAX_COMPONENTS: lim_depth = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, actual %0h %0h %0b %0b %0h",
                   $time, path_byte_i, key_byte_i, byte_valid_i, final_item_i, error_code_i);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          compare_field("path_byte", want.path_byte, path_byte_i);
          compare_field("key_byte", want.key_byte, key_byte_i);
          compare_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid_i));
          compare_field("final_item", 8'(want.final_item), 8'(final_item_i));
          compare_field("error_code", 8'(want.error_code), 8'(error_code_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_path_beat(in_byte_i, has_byte_i, end_of_path_i, want);
        owed_q.insert(owed_q.size(), want);
      end
      results_owed_o <= owed_q.size();
    end
  end

endmodule

[dv/tb_relative_path_validator.sv]
// Testbench top for the relative path validator: drives directed and random
// paths through several limit settings and idle patterns, then gives the verdict.
// Depends on rpv_pkg, relative_path_validator and rpv_result_checker.
`timescale 1ns / 1ps

module tb_relative_path_validator;
  import rpv_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBeats = 90;
  localparam int unsigned LongHold   = 200;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic [7:0]           in_byte_i     = '0;
  logic                 has_byte_i    = 1'b0;
  logic                 end_of_path_i = 1'b0;
  logic                 out_stall_i   = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [7:0]           path_byte_o;
  logic [7:0]           key_byte_o;
  logic                 byte_valid_o;
  logic                 final_item_o;
  logic [3:0]           error_code_o;
  logic                 cfg_ready_o;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned cycles     = 0;
  int unsigned beats_sent = 0;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_left  = 0;
  logic        hold_req   = 1'b0;

  logic [15:0] cur_path_lim;
  logic [9:0]  cur_comp_lim;
  logic [7:0]  cur_depth_lim;
  logic [7:0]  path_bytes[$];

  relative_path_validator dut (.*);

  rpv_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_path_i    (end_of_path_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .path_byte_i      (path_byte_o),
    .key_byte_i       (key_byte_o),
    .byte_valid_i     (byte_valid_o),
    .final_item_i     (final_item_o),
    .error_code_i     (error_code_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .results_owed_o   (results_owed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver holds off for a long stretch on request so the block backs up.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LongHold;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < stall_pct;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic has, input logic eop);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    has_byte_i    <= has;
    end_of_path_i <= eop;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (has || eop) beats_sent++;
  endtask

  task automatic send_path(input logic tail_item);
    for (int i = 0; i < path_bytes.size(); i++) begin
      if ($urandom_range(29) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(path_bytes[i], 1'b1, !tail_item && i == path_bytes.size() - 1);
    end
    if (tail_item) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] path_w, input logic [15:0] comp_w,
                            input logic [15:0] depth_w);
    write_reg(REG_MAX_PATH_BYTES, path_w);
    write_reg(REG_MAX_COMP_BYTES, comp_w);
    write_reg(REG_MAX_COMPONENTS, depth_w);
    cfg_valid_i   <= 1'b0;
    cur_path_lim  = path_w;
    cur_comp_lim  = comp_w[9:0];
    cur_depth_lim = depth_w[7:0];
  endtask

  function automatic logic [7:0] name_char();
    case ($urandom_range(4))
      0, 1: return 8'($urandom_range(8'h61, 8'h7a));
      2: return 8'($urandom_range(8'h41, 8'h5a));
      3: return 8'($urandom_range(8'h30, 8'h39));
      default: return $urandom_range(1) ? 8'h2d : 8'h5f;
    endcase
  endfunction

  function automatic logic [7:0] forbidden_char();
    string marks;
    marks = "<>:\"|?*";
    case ($urandom_range(2))
      0: return 8'($urandom_range(8'h1f));
      1: return 8'($urandom_range(8'h7f, 8'hff));
      default: return marks[$urandom_range(6)];
    endcase
  endfunction

  function automatic logic [7:0] separator();
    return $urandom_range(4) == 0 ? ChBSlash : ChSlash;
  endfunction

  function automatic string device_name();
    case ($urandom_range(8))
      0: return "CON";
      1: return "PRN";
      2: return "AUX";
      3: return "NUL";
      4: return "CLOCK$";
      5: return "CONIN$";
      6: return "CONOUT$";
      7: return $sformatf("COM%0d", $urandom_range(9));
      default: return $sformatf("LPT%0d", $urandom_range(9));
    endcase
  endfunction

  function automatic int unsigned near(input int unsigned lim);
    int unsigned n;
    n = lim + $urandom_range(2);
    return n > 1 ? n - 1 : 1;
  endfunction

  task automatic add_byte(input logic [7:0] c);
    path_bytes.insert(path_bytes.size(), c);
  endtask

  task automatic add_name(input int unsigned n);
    repeat (n) add_byte(name_char());
  endtask

  task automatic add_text(input string s, input logic mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= "A" && c <= "Z" && $urandom_range(1)) c = c | 8'h20;
      add_byte(c);
    end
  endtask

  task automatic add_extension();
    add_byte(ChDot);
    add_name($urandom_range(1, 3));
  endtask

  task automatic add_component(input logic clean);
    int unsigned kind;
    string       dev;
    kind = clean ? $urandom_range(59) : $urandom_range(99);
    dev  = device_name();
    if (kind < 35) begin
      add_name($urandom_range(1, 8));
      if ($urandom_range(2) == 0) add_extension();
    end else if (kind < 45) begin
      if ($urandom_range(1)) begin
        add_text(dev, 1'b1);
        add_name(1);
      end else begin
        add_text(dev.substr(0, dev.len() - 2), 1'b1);
      end
    end else if (kind < 52) begin
      add_byte(ChDot);
      add_name($urandom_range(1, 6));
    end else if (kind < 60) begin
      add_name($urandom_range(1, 6));
      add_byte(ChSpace);
      add_name($urandom_range(1, 8));
    end else if (kind < 70) begin
      add_text(dev, 1'b1);
      if ($urandom_range(1)) add_extension();
    end else if (kind < 76) begin
      repeat ($urandom_range(1, 3)) add_byte(ChDot);
    end else if (kind < 82) begin
      add_name($urandom_range(1, 6));
      add_byte($urandom_range(1) ? ChDot : ChSpace);
    end else if (kind < 88) begin
      add_name($urandom_range(0, 4));
      add_byte(forbidden_char());
      if ($urandom_range(1)) add_name($urandom_range(1, 4));
    end else if (kind < 93) begin
    end else begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
    end
  endtask

  task automatic build_path();
    int unsigned flavor;
    int unsigned parts;
    logic        clean;
    path_bytes.delete();
    flavor = $urandom_range(99);
    if (flavor < 2) return;
    clean = flavor < 72;
    if (!clean) begin
      case ($urandom_range(5))
        0: add_byte(separator());
        1: begin
          add_byte(name_char());
          add_byte(ChColon);
        end
        default: ;
      endcase
    end
    parts = $urandom_range(1, 5);
    for (int i = 0; i < parts; i++) begin
      if (i != 0) add_byte(separator());
      add_component(clean);
    end
    if (!clean && $urandom_range(4) == 0) add_byte(separator());
  endtask

  // Paths sized around one limit: many components, one long component, or many bytes.
  task automatic build_stretched(input int unsigned shape, input int unsigned n);
    path_bytes.delete();
    for (int i = 0; i < n; i++) begin
      case (shape)
        0: begin
          if (i != 0) add_byte(separator());
          add_byte(name_char());
        end
        1: add_byte(name_char());
        default: add_byte(i % 6 == 5 ? separator() : name_char());
      endcase
    end
  endtask

  task automatic pick_path();
    case ($urandom_range(39))
      0: if (cur_depth_lim <= 64) build_stretched(0, near(cur_depth_lim)); else build_path();
      1: if (cur_comp_lim <= 300) build_stretched(1, near(cur_comp_lim)); else build_path();
      2: if (cur_path_lim <= 300) build_stretched(2, near(cur_path_lim)); else build_path();
      default: build_path();
    endcase
  endtask

  task automatic directed_text(input string s, input logic tail_item);
    path_bytes.delete();
    add_text(s, 1'b0);
    send_path(tail_item);
  endtask

  initial begin
    int unsigned target;
    cur_path_lim  = MaxPathReset;
    cur_comp_lim  = MaxCompReset;
    cur_depth_lim = MaxCountReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_text("", 1'b1);
    directed_text("Ab", 1'b1);
    directed_text("/x", 1'b0);
    directed_text("C:", 1'b0);
    directed_text("a/", 1'b0);
    directed_text("..", 1'b0);
    directed_text("CON", 1'b0);
    directed_text("x\\y", 1'b0);
    directed_text("z.", 1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);
    path_bytes.delete();
    add_byte(8'h00);
    add_byte(8'hFF);
    send_path(1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: set_limits(16'd4096, 16'hFCFF, 16'hA520);
        1: set_limits(16'hFFFF, 16'd1023, 16'd255);
        2: set_limits(16'd1, 16'd1, 16'd1);
        3: set_limits(16'd0, 16'd0, 16'd0);
        4: set_limits(16'd40, 16'd6, 16'd4);
        5: set_limits(16'd12, 16'd3, 16'd2);
        6: set_limits(16'($urandom_range(1, 300)), 16'($urandom_range(1, 20)),
                      16'($urandom_range(1, 10)));
        default: set_limits(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      case (phase % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
          hold_req  = 1'b1;
        end
        1: begin
          gap_pct   = 70;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 70;
        end
        default: begin
          gap_pct   = 10;
          stall_pct = 10;
        end
      endcase
      if (phase == 1) begin
        build_stretched(0, 257);
        send_path(1'b0);
      end
      target = beats_sent + PhaseBeats;
      while (beats_sent < target) begin
        pick_path();
        send_path(path_bytes.size() == 0 || $urandom_range(5) == 0);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
